>>> hdl/kiss_frame_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// KISS frame decoder assertion macros
// Concurrent assertion helpers used by the decoder back end.
// ----------------------------------------------------------------------------
`ifndef KISS_FRAME_DECODER_TOP_ASSERT_SVH
`define KISS_FRAME_DECODER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define KFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kfd assertion failed");
`define KFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kfd assertion failed");
`else
`define KFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/kfd_pkg.sv
// ----------------------------------------------------------------------------
// KISS frame decoder package
// Shared types, constants and the line byte classifier.
// ----------------------------------------------------------------------------
package kfd_pkg;

    localparam int MAX_FRAME = 1024;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);
    localparam int QDEPTH    = 2;
    localparam int QIDX_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    localparam logic CFG_PORT_MASK = 1'b0;
    localparam logic CFG_MAX_LEN   = 1'b1;

    typedef enum logic [1:0] {
        K_DATA,
        K_FESC,
        K_FEND,
        K_POP
    } t_kind;

    typedef enum logic {
        BS_IDLE,
        BS_READ
    } t_bstate;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       accepted;
        logic       out_valid;
        logic [7:0] out_byte;
        logic [3:0] out_port;
        logic       out_last;
    } t_out;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic [15:0] port_mask;
        logic [10:0] max_len;
    } t_cfg;

    function automatic t_kind classify(input t_in d);
        t_kind k;
        if (d.op) begin
            k = K_POP;
        end else if (d.rx_byte == FEND) begin
            k = K_FEND;
        end else if (d.rx_byte == FESC) begin
            k = K_FESC;
        end else begin
            k = K_DATA;
        end
        return k;
    endfunction

endpackage

>>> hdl/kfd_front.sv
// ----------------------------------------------------------------------------
// KISS frame decoder front end
// Accepts input transactions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module kfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  kfd_pkg::t_in    i_in,
    output kfd_pkg::t_qhead o_head,
    input  logic            i_take
);

    kfd_pkg::t_item              r_q [kfd_pkg::QDEPTH];
    logic [kfd_pkg::QIDX_W-1:0] r_wp, n_wp;
    logic [kfd_pkg::QIDX_W-1:0] r_rp, n_rp;
    logic [kfd_pkg::QCNT_W-1:0] r_count, n_count;
    logic                        wr;
    kfd_pkg::t_item              new_item;

    assign o_in_stall = (r_count == kfd_pkg::QCNT_W'(kfd_pkg::QDEPTH));
    assign wr         = i_in_valid && !o_in_stall;

    always_comb begin
        new_item.kind = kfd_pkg::classify(i_in);
        new_item.data = i_in.rx_byte;
        n_wp          = wr ? r_wp + 1'b1 : r_wp;
        n_rp          = i_take ? r_rp + 1'b1 : r_rp;
        n_count       = r_count + kfd_pkg::QCNT_W'(wr) - kfd_pkg::QCNT_W'(i_take);
        o_head.valid  = (r_count != '0);
        o_head.item   = r_q[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= new_item;
        end
    end

endmodule

>>> hdl/kfd_back.sv
// ----------------------------------------------------------------------------
// KISS frame decoder back end
// Unescapes and stores frames, checks them at the end marker and delivers
// payload bytes through a registered output stage.
// ----------------------------------------------------------------------------
`include "kiss_frame_decoder_top_assert.svh"

module kfd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kfd_pkg::t_cfg   i_cfg,
    input  kfd_pkg::t_qhead i_head,
    output logic            o_take,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output kfd_pkg::t_out   o_out
);

    logic [7:0] r_mem [kfd_pkg::MAX_FRAME];

    kfd_pkg::t_bstate            r_state, n_state;
    logic                        r_esc, n_esc;
    logic                        r_bad, n_bad;
    logic                        r_ready, n_ready;
    logic [kfd_pkg::LEN_W-1:0]   r_len, n_len;
    logic [kfd_pkg::LEN_W-1:0]   r_pos, n_pos;
    logic [3:0]                  r_port, n_port;
    logic [7:0]                  r_hdr, n_hdr;
    logic                        r_out_valid;
    kfd_pkg::t_out               r_out, n_out;
    logic [7:0]                  r_rd_data;

    logic                        out_free;
    logic                        load;
    logic                        mem_we;
    logic                        mem_re;
    logic                        do_store;
    logic [7:0]                  wbyte;
    logic [kfd_pkg::LEN_W-1:0]   lim;
    logic [3:0]                  hport;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign hport       = r_hdr[7:4];

    always_comb begin
        if (32'(i_cfg.max_len) > 32'(kfd_pkg::MAX_FRAME)) begin
            lim = kfd_pkg::LEN_W'(kfd_pkg::MAX_FRAME);
        end else begin
            lim = kfd_pkg::LEN_W'(i_cfg.max_len);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_esc    = r_esc;
        n_bad    = r_bad;
        n_ready  = r_ready;
        n_len    = r_len;
        n_pos    = r_pos;
        n_port   = r_port;
        n_hdr    = r_hdr;
        n_out    = '0;
        o_take   = 1'b0;
        load     = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        do_store = 1'b0;
        wbyte    = i_head.item.data;
        case (r_state)
            kfd_pkg::BS_IDLE: begin
                if (i_head.valid && out_free) begin
                    o_take = 1'b1;
                    load   = 1'b1;
                    if (i_head.item.kind == kfd_pkg::K_POP) begin
                        if (r_ready) begin
                            load    = 1'b0;
                            mem_re  = 1'b1;
                            n_state = kfd_pkg::BS_READ;
                        end
                    end else if (!r_ready) begin
                        n_out.accepted = 1'b1;
                        case (i_head.item.kind)
                            kfd_pkg::K_FEND: begin
                                n_esc = 1'b0;
                                if (r_bad) begin
                                    n_bad = 1'b0;
                                    n_len = '0;
                                end else if (r_len != '0) begin
                                    if (r_hdr[3:0] != 4'h0 || !i_cfg.port_mask[hport]
                                        || r_len < kfd_pkg::LEN_W'(2)) begin
                                        n_len = '0;
                                    end else begin
                                        n_port  = hport;
                                        n_pos   = kfd_pkg::LEN_W'(1);
                                        n_ready = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                if (!r_bad) begin
                                    if (r_esc) begin
                                        n_esc = 1'b0;
                                        if (i_head.item.data == kfd_pkg::TFEND) begin
                                            wbyte    = kfd_pkg::FEND;
                                            do_store = 1'b1;
                                        end else if (i_head.item.data == kfd_pkg::TFESC) begin
                                            wbyte    = kfd_pkg::FESC;
                                            do_store = 1'b1;
                                        end else begin
                                            n_bad = 1'b1;
                                        end
                                    end else if (i_head.item.kind == kfd_pkg::K_FESC) begin
                                        n_esc = 1'b1;
                                    end else begin
                                        do_store = 1'b1;
                                    end
                                end
                                if (do_store) begin
                                    if (r_len >= lim) begin
                                        n_bad = 1'b1;
                                    end else begin
                                        mem_we = 1'b1;
                                        n_len  = r_len + 1'b1;
                                        if (r_len == '0) begin
                                            n_hdr = wbyte;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            kfd_pkg::BS_READ: begin
                load            = 1'b1;
                n_out.out_valid = 1'b1;
                n_out.out_byte  = r_rd_data;
                n_out.out_port  = r_port;
                n_out.out_last  = (r_pos + 1'b1 >= r_len);
                n_pos           = r_pos + 1'b1;
                n_state         = kfd_pkg::BS_IDLE;
                if (n_out.out_last) begin
                    n_ready = 1'b0;
                    n_len   = '0;
                    n_pos   = '0;
                end
            end
            default: begin
                n_state = kfd_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kfd_pkg::BS_IDLE;
            r_esc       <= 1'b0;
            r_bad       <= 1'b0;
            r_ready     <= 1'b0;
            r_len       <= '0;
            r_pos       <= '0;
            r_port      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_esc   <= n_esc;
            r_bad   <= n_bad;
            r_ready <= n_ready;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_port  <= n_port;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_len[kfd_pkg::ADDR_W-1:0]] <= wbyte;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_pos[kfd_pkg::ADDR_W-1:0]];
        end
    end

    `KFD_ASSERT_IMPLY(a_ready_bounds, i_clk, i_rst_n, r_ready, (r_len >= kfd_pkg::LEN_W'(2)) && (r_pos != '0) && (r_pos < r_len))
    `KFD_ASSERT_IMPLY(a_no_store_when_ready, i_clk, i_rst_n, mem_we, !r_ready && !r_bad)
    `KFD_ASSERT_NEXT(a_read_delivers, i_clk, i_rst_n, r_state == kfd_pkg::BS_READ, r_out_valid && r_out.out_valid)

endmodule

>>> hdl/kiss_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// KISS frame decoder top level
// Unescapes a KISS line byte stream into frames and delivers payload bytes.
//
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in  (op, rx_byte)
// out       output     o_out_valid / i_out_stall o_out (accepted, out_valid,
//                                                       out_byte, out_port,
//                                                       out_last)
// cfg       input      i_cfg_we                 i_cfg_idx, i_cfg_data
//
// A line byte and an empty pop are handled in the back end's idle state, and a
// pop that delivers also passes through the read state as the store read is registered.
// A two-entry queue separates input acceptance from execution.
// Reset is synchronous and needs no clearing pass over the frame store.
// A stalled output holds its transaction while the queue keeps filling.
// ----------------------------------------------------------------------------
module kiss_frame_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kfd_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output kfd_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);

    kfd_pkg::t_cfg   r_cfg;
    kfd_pkg::t_qhead head;
    logic            take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.port_mask <= 16'h0001;
            r_cfg.max_len   <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kfd_pkg::CFG_PORT_MASK: r_cfg.port_mask <= i_cfg_data;
                kfd_pkg::CFG_MAX_LEN:   r_cfg.max_len   <= i_cfg_data[10:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    kfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_head     (head),
        .i_take     (take)
    );

    kfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> dv/kiss_frame_decoder_checker.sv
// ----------------------------------------------------------------------------
// KISS frame decoder checker
// Watches the input, output and register ports of the decoder. It keeps its
// own copy of the unescaping, framing and delivery state, works out the result
// of every accepted input transaction, and compares each accepted output
// transaction field by field with the oldest pending decoded result.
// ----------------------------------------------------------------------------
module kiss_frame_decoder_checker
    import kfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_LINE      = 1'b0;
    localparam int   REPORT_LIMIT = 10;

    logic [15:0] port_mask;
    logic [10:0] len_limit_reg;
    logic [7:0]  frame_bytes [MAX_FRAME];
    int          held_len;
    int          read_idx;
    logic        esc_seen;
    logic        frame_broken;
    logic        frame_waiting;
    logic [3:0]  frame_port;
    t_out        decoded_q [$];
    int          mismatch_cnt = 0;

    function automatic t_out decode_item(input t_in d);
        t_out       r;
        logic [7:0] b;
        logic       keep;
        int         cap;
        r = '0;
        cap = (len_limit_reg > MAX_FRAME) ? MAX_FRAME : int'(len_limit_reg);
        if (d.op == OP_LINE) begin
            if (!frame_waiting) begin
                r.accepted = 1'b1;
                b = d.rx_byte;
                if (b == FEND) begin
                    esc_seen = 1'b0;
                    if (frame_broken) begin
                        frame_broken = 1'b0;
                        held_len = 0;
                    end else if (held_len != 0) begin
                        if (frame_bytes[0][3:0] != 4'h0 || !port_mask[frame_bytes[0][7:4]]
                                || held_len < 2) begin
                            held_len = 0;
                        end else begin
                            frame_port = frame_bytes[0][7:4];
                            read_idx = 1;
                            frame_waiting = 1'b1;
                        end
                    end
                end else if (!frame_broken) begin
                    keep = 1'b1;
                    if (esc_seen) begin
                        esc_seen = 1'b0;
                        if (b == TFEND) begin
                            b = FEND;
                        end else if (b == TFESC) begin
                            b = FESC;
                        end else begin
                            frame_broken = 1'b1;
                            keep = 1'b0;
                        end
                    end else if (b == FESC) begin
                        esc_seen = 1'b1;
                        keep = 1'b0;
                    end
                    if (keep) begin
                        if (held_len >= cap) begin
                            frame_broken = 1'b1;
                        end else begin
                            frame_bytes[held_len] = b;
                            held_len++;
                        end
                    end
                end
            end
        end else if (frame_waiting && read_idx < held_len) begin
            r.out_valid = 1'b1;
            r.out_byte  = frame_bytes[read_idx];
            r.out_port  = frame_port;
            r.out_last  = (read_idx + 1 >= held_len);
            read_idx++;
            if (r.out_last) begin
                frame_waiting = 1'b0;
                held_len = 0;
                read_idx = 0;
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            port_mask     = 16'h0001;
            len_limit_reg = 11'd1024;
            held_len      = 0;
            read_idx      = 0;
            esc_seen      = 1'b0;
            frame_broken  = 1'b0;
            frame_waiting = 1'b0;
            frame_port    = 4'h0;
            decoded_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PORT_MASK) begin
                    port_mask = i_cfg_data;
                end else begin
                    len_limit_reg = i_cfg_data[10:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decoded_q.push_back(decode_item(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    note_failure($sformatf("output transaction %h with none pending", i_out));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("accepted", want.accepted, i_out.accepted);
                    check_field("out_valid", want.out_valid, i_out.out_valid);
                    check_field("out_byte", want.out_byte, i_out.out_byte);
                    check_field("out_port", want.out_port, i_out.out_port);
                    check_field("out_last", want.out_last, i_out.out_last);
                end
            end
        end
        o_results_due <= decoded_q.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

>>> dv/tb_kiss_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// KISS frame decoder testbench
// Drives directed and random KISS line traffic and pops into the decoder,
// steps through several register settings including the extremes, and applies
// random idle and stall bursts plus one long output hold. The checker module
// compares every output transaction and the verdict is given here.
// ----------------------------------------------------------------------------
module tb_kiss_frame_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kfd_pkg::*;

    localparam logic OP_LINE     = 1'b0;
    localparam logic OP_POP      = 1'b1;
    localparam int   LONG_HOLD   = 300;
    localparam int   QUIET_LIMIT = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in        = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = 1'b0;
    logic [15:0] i_cfg_data  = 16'h0000;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out;

    int          mismatch_total;
    int          results_due;
    int          quiet_cycles = 0;
    int          lines_sent   = 0;
    logic [15:0] mask_now     = 16'h0001;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    bit          hold_out     = 1'b0;

    kiss_frame_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    kiss_frame_decoder_checker frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatch_total),
        .o_results_due (results_due)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_out) begin
                hold_out = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_in d);
        i_in_valid <= 1'b1;
        i_in       <= d;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_line(input logic [7:0] b);
        lines_sent++;
        send_item(t_in'{op: OP_LINE, rx_byte: b});
    endtask

    task automatic send_pop();
        send_item(t_in'{op: OP_POP, rx_byte: 8'($urandom)});
    endtask

    task automatic send_coded(input logic [7:0] b);
        if (b == FEND) begin
            send_line(FESC);
            send_line(TFEND);
        end else if (b == FESC) begin
            send_line(FESC);
            send_line(TFESC);
        end else begin
            send_line(b);
        end
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_PORT_MASK) begin
            mask_now = val;
        end
    endtask

    task automatic send_frame(input int payload_len, input bit clean, inout int tally);
        logic [7:0] hdr;
        logic [7:0] b;
        logic [3:0] port;
        int         first_line;
        first_line = lines_sent;
        send_line(FEND);
        port = 4'($urandom);
        if (mask_now != 16'h0000) begin
            while (!mask_now[port]) begin
                port = 4'($urandom);
            end
        end
        hdr = {port, 4'h0};
        if (!clean && $urandom_range(0, 9) < 2) begin
            hdr = 8'($urandom);
        end
        send_coded(hdr);
        repeat (payload_len) begin
            b = 8'($urandom);
            if ($urandom_range(0, 7) == 0) begin
                b = $urandom_range(0, 1) ? FEND : FESC;
            end
            if (!clean && $urandom_range(0, 39) == 0) begin
                send_pop();
            end
            if (!clean && $urandom_range(0, 59) == 0) begin
                send_line(8'($urandom));
            end else if (!clean && $urandom_range(0, 79) == 0) begin
                send_line(FESC);
                send_line(8'($urandom));
            end else begin
                send_coded(b);
            end
        end
        if (!clean && $urandom_range(0, 29) == 0) begin
            send_line(FESC);
        end
        send_line(FEND);
        tally += lines_sent - first_line + payload_len;
        if (!clean && $urandom_range(0, 9) == 0) begin
            send_line(8'($urandom));
        end
        repeat (payload_len + $urandom_range(0, 1)) begin
            send_pop();
        end
    endtask

    task automatic run_frames(input int target, input int long_odds);
        int tally;
        int len;
        tally = 0;
        while (tally < target) begin
            len = $urandom_range(1, 12);
            if (long_odds != 0 && $urandom_range(1, long_odds) == 1) begin
                len = $urandom_range(250, 300);
            end
            send_frame(len, 1'b0, tally);
        end
    endtask

    initial begin
        int tally;
        tally = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty pop, then a frame end with nothing stored.
        send_pop();
        send_line(FEND);
        // Frame with both escape forms, then a line byte while it waits.
        send_line(8'h00);
        send_line(8'h00);
        send_line(8'hFF);
        send_line(FESC);
        send_line(TFEND);
        send_line(FESC);
        send_line(TFESC);
        send_line(FEND);
        send_line(8'h5A);
        repeat (5) send_pop();
        // Header only, a bad escape, a command frame and a disabled port.
        send_line(8'h00);
        send_line(FEND);
        send_line(8'h00);
        send_line(FESC);
        send_line(8'h41);
        send_line(FEND);
        send_line(8'h01);
        send_line(8'h44);
        send_line(FEND);
        send_line(8'h10);
        send_line(8'h55);
        send_line(FEND);

        run_frames(80, 0);
        hold_out = 1'b1;
        run_frames(80, 0);
        drain_all();

        // A frame that fills the length limit exactly.
        write_reg(CFG_PORT_MASK, 16'hFFFF);
        write_reg(CFG_MAX_LEN, 16'd256);
        send_frame(255, 1'b1, tally);
        run_frames(60, 0);
        drain_all();

        write_reg(CFG_PORT_MASK, 16'h0000);
        write_reg(CFG_MAX_LEN, 16'd1024);
        run_frames(40, 0);
        drain_all();

        write_reg(CFG_PORT_MASK, 16'($urandom));
        write_reg(CFG_MAX_LEN, 16'hF805);
        run_frames(80, 0);
        drain_all();

        write_reg(CFG_MAX_LEN, 16'h0000);
        run_frames(40, 0);
        drain_all();

        write_reg(CFG_PORT_MASK, 16'hFFFF);
        write_reg(CFG_MAX_LEN, 16'h07FF);
        run_frames(60, 0);
        drain_all();

        write_reg(CFG_PORT_MASK, 16'($urandom) | 16'h0001);
        write_reg(CFG_MAX_LEN, 16'($urandom_range(256, 1024)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_frames(120, 0);
        drain_all();

        repeat (20) @(posedge i_clk);
        if (mismatch_total == 0 && results_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/kfd_pkg.sv
hdl/kfd_front.sv
hdl/kfd_back.sv
hdl/kiss_frame_decoder_top.sv
dv/kiss_frame_decoder_checker.sv
dv/tb_kiss_frame_decoder_top.sv
